/* hdl/flrt_pkg.sv */
// Package for the flash ring log slot tracker.
// Holds sizes, header constants, event codes and the structs shared by the tracker modules.
// No dependencies.
package flrt_pkg;

  localparam int MAX_PAGES = 4096;
  localparam int MAP_BITS  = 64;
  localparam int MAP_WORDS = MAX_PAGES / MAP_BITS;
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int OFF_W     = $clog2(MAP_BITS);
  localparam int PAGE_W    = 12;
  localparam int SUM_W     = ((PAGE_W > 8) ? PAGE_W : 8) + 1;
  localparam int NPCFG_W   = 13;
  localparam int L2CFG_W   = 3;
  localparam int CNT_W     = 32;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [CNT_W-1:0] NONE_SEQ  = 32'hffff_ffff;
  localparam logic [CNT_W-1:0] SEQ_LOW   = 32'h4000_0000;
  localparam logic [CNT_W-1:0] SEQ_HIGH  = 32'hc000_0000;
  localparam logic [CNT_W-1:0] SEQ_HALF  = 32'h8000_0000;
  localparam logic [CNT_W-1:0] REC_MAGIC = 32'h5d00_5d00;

  localparam logic [NPCFG_W-1:0] NUM_PAGES_RST = 13'd4096;
  localparam logic [L2CFG_W-1:0] PPB_LOG2_RST  = 3'd5;

  typedef enum logic {
    REG_NUM_PAGES = 1'b0,
    REG_PPB_LOG2  = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    MODE_SCAN   = 3'd0,
    MODE_FINISH = 3'd1,
    MODE_WRITE  = 3'd2,
    MODE_ALIGN  = 3'd3,
    MODE_BAD    = 3'd4,
    MODE_ERASED = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WB,
    ST_CLR2
  } state_e;

  typedef struct packed {
    logic                wr;
    logic                set;
    logic                clr2;
    logic [ADDR_W-1:0]   addr;
    logic [ADDR_W-1:0]   addr_b;
    logic [MAP_BITS-1:0] mask;
  } map_op_t;

  typedef struct packed {
    logic [PAGE_W-1:0] np;
    logic [CNT_W-1:0]  count;
    logic              all_bad;
  } pos_t;

endpackage

/* hdl/flrt_map_ram.sv */
// Page-used bitmap memory: one write port, two registered read ports.
// Row valid flags make unwritten rows read as zero after reset.
// Depends on flrt_pkg.
module flrt_map_ram (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           rd_en_i,
  input  logic [flrt_pkg::ADDR_W-1:0]    rd_addr_a_i,
  input  logic [flrt_pkg::ADDR_W-1:0]    rd_addr_b_i,
  output logic [flrt_pkg::MAP_BITS-1:0]  rd_data_a_o,
  output logic [flrt_pkg::MAP_BITS-1:0]  rd_data_b_o,
  input  logic                           wr_en_i,
  input  logic [flrt_pkg::ADDR_W-1:0]    wr_addr_i,
  input  logic [flrt_pkg::MAP_BITS-1:0]  wr_data_i
);
  import flrt_pkg::*;

  logic [MAP_BITS-1:0]  mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld_q;
  logic [MAP_BITS-1:0]  data_a_q;
  logic [MAP_BITS-1:0]  data_b_q;
  logic                 rvld_a_q;
  logic                 rvld_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      data_a_q <= mem[rd_addr_a_i];
      data_b_q <= mem[rd_addr_b_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rvld_a_q <= 1'b0;
      rvld_b_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_a_q <= vld_q[rd_addr_a_i];
        rvld_b_q <= vld_q[rd_addr_b_i];
      end
    end
  end

  assign rd_data_a_o = rvld_a_q ? data_a_q : '0;
  assign rd_data_b_o = rvld_b_q ? data_b_q : '0;

endmodule

/* hdl/flrt_pos_unit.sv */
// Write position, sequence count, newest-record tracker and bad-block skip count.
// Decodes each transaction into a bitmap read-modify-write operation.
// Depends on flrt_pkg.
module flrt_pos_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  flrt_pkg::mode_e               mode_i,
  input  logic [flrt_pkg::PAGE_W-1:0]   page_i,
  input  logic                          page_bad_i,
  input  logic                          read_ok_i,
  input  logic [flrt_pkg::CNT_W-1:0]    seq_word_i,
  input  logic [flrt_pkg::CNT_W-1:0]    magic_word_i,
  input  logic                          panic_i,
  input  logic [flrt_pkg::NPCFG_W-1:0]  cfg_num_pages_i,
  input  logic [flrt_pkg::L2CFG_W-1:0]  cfg_ppb_log2_i,
  output flrt_pkg::map_op_t             op_o,
  output flrt_pkg::pos_t                pos_o
);
  import flrt_pkg::*;

  logic [PAGE_W-1:0]   np_q, np_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    best_cnt_q, best_cnt_d;
  logic [PAGE_W-1:0]   best_pg_q, best_pg_d;
  logic [SUM_W-1:0]    bs_q, bs_d;

  logic [SUM_W-1:0]    eff;
  logic [SUM_W-1:0]    ppb;
  logic [SUM_W-1:0]    ppb_m1;
  logic [SUM_W-1:0]    blocks;
  logic [SUM_W-1:0]    np_ext;
  logic [SUM_W-1:0]    base_np;
  logic [CNT_W-1:0]    base_cnt;
  logic [SUM_W-1:0]    inc_np;
  logic [SUM_W-1:0]    adv_np;
  logic [CNT_W-1:0]    inc_cnt;
  logic [CNT_W-1:0]    adv_cnt;
  logic [SUM_W-1:0]    up_np;
  logic [SUM_W-1:0]    al_np;
  logic [SUM_W-1:0]    sk_np;
  logic                done_now;
  logic                scan_ok;
  logic                blank;
  logic                rec;
  logic                take;
  logic [OFF_W-1:0]    blk_off;
  logic [MAP_BITS-1:0] blk_mask;

  always_comb begin
    if (32'(cfg_num_pages_i) > 32'(MAX_PAGES)) begin
      eff = SUM_W'(MAX_PAGES);
    end else if (cfg_num_pages_i == '0) begin
      eff = SUM_W'(1);
    end else begin
      eff = SUM_W'(cfg_num_pages_i);
    end
    ppb      = SUM_W'(1) << cfg_ppb_log2_i;
    ppb_m1   = ppb - SUM_W'(1);
    blocks   = eff >> cfg_ppb_log2_i;
    np_ext   = SUM_W'(np_q);
    done_now = (bs_q != '0) && (bs_q >= blocks);
  end

  always_comb begin
    if (mode_i == MODE_FINISH) begin
      base_np  = (best_cnt_q == NONE_SEQ) ? (eff - SUM_W'(1)) : SUM_W'(best_pg_q);
      base_cnt = (best_cnt_q == NONE_SEQ) ? '0 : best_cnt_q;
    end else begin
      base_np  = np_ext;
      base_cnt = cnt_q;
    end
    inc_np  = base_np + SUM_W'(1);
    adv_np  = (inc_np >= eff) ? '0 : inc_np;
    inc_cnt = base_cnt + CNT_W'(1);
    adv_cnt = (inc_cnt == NONE_SEQ) ? '0 : inc_cnt;
    up_np   = ((np_ext >> cfg_ppb_log2_i) + SUM_W'(1)) << cfg_ppb_log2_i;
    if ((np_ext & ppb_m1) != '0) begin
      al_np = (up_np >= eff) ? '0 : up_np;
    end else begin
      al_np = np_ext;
    end
    sk_np = ((np_ext + ppb) >= eff) ? '0 : (np_ext + ppb);
  end

  always_comb begin
    scan_ok = (SUM_W'(page_i) < eff) && !page_bad_i;
    blank   = read_ok_i && (seq_word_i == NONE_SEQ) && (magic_word_i == NONE_SEQ);
    rec     = read_ok_i && (seq_word_i != NONE_SEQ) && (magic_word_i == REC_MAGIC);
    take    = (best_cnt_q == NONE_SEQ)
           || ((seq_word_i < SEQ_LOW) && (best_cnt_q > SEQ_HIGH))
           || ((seq_word_i > best_cnt_q) && (seq_word_i < SEQ_HIGH))
           || ((seq_word_i > best_cnt_q) && (seq_word_i > SEQ_HIGH)
               && (best_cnt_q > SEQ_HALF));
    blk_off  = np_q[OFF_W-1:0] & ~ppb_m1[OFF_W-1:0];
    blk_mask = ((MAP_BITS'(1) << ppb) - MAP_BITS'(1)) << blk_off;
  end

  always_comb begin
    np_d       = np_q;
    cnt_d      = cnt_q;
    best_cnt_d = best_cnt_q;
    best_pg_d  = best_pg_q;
    bs_d       = bs_q;
    op_o.wr    = 1'b0;
    op_o.set   = 1'b0;
    op_o.clr2  = 1'b0;
    op_o.addr  = np_q[PAGE_W-1:OFF_W];
    op_o.mask  = MAP_BITS'(1) << np_q[OFF_W-1:0];
    case (mode_i)
      MODE_SCAN: begin
        op_o.addr = page_i[PAGE_W-1:OFF_W];
        op_o.mask = MAP_BITS'(1) << page_i[OFF_W-1:0];
        op_o.wr   = scan_ok;
        op_o.set  = !blank;
        if (scan_ok && rec && take) begin
          best_cnt_d = seq_word_i;
          best_pg_d  = page_i;
        end
      end
      MODE_FINISH: begin
        np_d       = PAGE_W'(adv_np);
        cnt_d      = adv_cnt;
        best_cnt_d = NONE_SEQ;
        best_pg_d  = '0;
      end
      MODE_WRITE: begin
        op_o.wr  = 1'b1;
        op_o.set = 1'b1;
        if (!panic_i) begin
          np_d  = PAGE_W'(adv_np);
          cnt_d = adv_cnt;
        end
      end
      MODE_ALIGN: begin
        bs_d = '0;
        np_d = PAGE_W'(al_np);
      end
      MODE_BAD: begin
        if (!done_now) begin
          bs_d = bs_q + SUM_W'(1);
          np_d = PAGE_W'(sk_np);
        end
      end
      MODE_ERASED: begin
        op_o.wr   = 1'b1;
        op_o.set  = 1'b0;
        op_o.mask = blk_mask;
        op_o.clr2 = ppb > SUM_W'(MAP_BITS);
      end
      default: begin
      end
    endcase
    op_o.addr_b = np_d[PAGE_W-1:OFF_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_q       <= '0;
      cnt_q      <= '0;
      best_cnt_q <= NONE_SEQ;
      best_pg_q  <= '0;
      bs_q       <= '0;
    end else if (accept_i) begin
      np_q       <= np_d;
      cnt_q      <= cnt_d;
      best_cnt_q <= best_cnt_d;
      best_pg_q  <= best_pg_d;
      bs_q       <= bs_d;
    end
  end

  assign pos_o.np      = np_q;
  assign pos_o.count   = cnt_q;
  assign pos_o.all_bad = done_now;

endmodule

/* hdl/flash_ring_log_slot_tracker_core.sv */
// Top level of the flash ring log slot tracker: event sequencer, register port, result register.
// Depends on flrt_pkg, flrt_pos_unit and flrt_map_ram.
//
// Each event passes through accept and write-back: the accept cycle updates the position state
// and reads the affected bitmap word and the word of the new write page; write-back writes a
// changed word back and loads the result register. An erase event on a 128-page block clears
// two bitmap words, the second in the clear state ST_CLR2. A stalled consumer holding a result
// keeps the block in write-back. The bitmap reads as all clear after reset with no clearing pass.
module flash_ring_log_slot_tracker_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [flrt_pkg::PADDR_W-1:0]   paddr,
  input  logic [flrt_pkg::PDATA_W-1:0]   pwdata,
  output logic [flrt_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0]                     mode_i,
  input  logic [flrt_pkg::PAGE_W-1:0]    page_i,
  input  logic                           page_bad_i,
  input  logic                           read_ok_i,
  input  logic [flrt_pkg::CNT_W-1:0]     seq_word_i,
  input  logic [flrt_pkg::CNT_W-1:0]     magic_word_i,
  input  logic                           panic_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [flrt_pkg::PAGE_W-1:0]    next_page_out_o,
  output logic [flrt_pkg::CNT_W-1:0]     next_count_out_o,
  output logic                           need_erase_o,
  output logic                           all_bad_o
);
  import flrt_pkg::*;

  state_e               state_q, state_d;
  map_op_t              op_d, op_q;
  pos_t                 pos;
  logic [NPCFG_W-1:0]   cfg_np_q;
  logic [L2CFG_W-1:0]   cfg_l2_q;
  logic                 cfg_we;
  reg_idx_e             cfg_idx;
  logic                 accept;
  logic                 out_free;
  logic                 load;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [MAP_BITS-1:0]  ram_wdata;
  logic [MAP_BITS-1:0]  rd_a;
  logic [MAP_BITS-1:0]  rd_b;
  logic [MAP_BITS-1:0]  new_word;
  logic [MAP_BITS-1:0]  word_b;
  logic                 out_valid_q, out_valid_d;
  logic [PAGE_W-1:0]    out_np_q;
  logic [CNT_W-1:0]     out_cnt_q;
  logic                 out_ne_q;
  logic                 out_ab_q;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_np_q <= NUM_PAGES_RST;
      cfg_l2_q <= PPB_LOG2_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_NUM_PAGES: cfg_np_q <= pwdata[NPCFG_W-1:0];
        REG_PPB_LOG2:  cfg_l2_q <= pwdata[L2CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_NUM_PAGES: prdata = PDATA_W'(cfg_np_q);
      REG_PPB_LOG2:  prdata = PDATA_W'(cfg_l2_q);
      default:       prdata = '0;
    endcase
  end

  flrt_pos_unit u_pos (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .mode_i          (mode_e'(mode_i)),
    .page_i          (page_i),
    .page_bad_i      (page_bad_i),
    .read_ok_i       (read_ok_i),
    .seq_word_i      (seq_word_i),
    .magic_word_i    (magic_word_i),
    .panic_i         (panic_i),
    .cfg_num_pages_i (cfg_np_q),
    .cfg_ppb_log2_i  (cfg_l2_q),
    .op_o            (op_d),
    .pos_o           (pos)
  );

  flrt_map_ram u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr_a_i (op_d.addr),
    .rd_addr_b_i (op_d.addr_b),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b),
    .wr_en_i     (ram_we),
    .wr_addr_i   (ram_waddr),
    .wr_data_i   (ram_wdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign new_word = op_q.set ? (rd_a | op_q.mask) : (rd_a & ~op_q.mask);
  assign word_b   = (op_q.wr && (op_q.addr == op_q.addr_b)) ? new_word : rd_b;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_WB;
      ST_WB:   if (out_free) state_d = op_q.clr2 ? ST_CLR2 : ST_IDLE;
      ST_CLR2: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    accept     = (state_q == ST_IDLE) && in_valid_i;
    load       = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = op_q.addr;
    ram_wdata  = new_word;
    unique case (state_q)
      ST_IDLE: begin
      end
      ST_WB: begin
        load   = out_free;
        ram_we = out_free && op_q.wr;
      end
      ST_CLR2: begin
        ram_we    = 1'b1;
        ram_waddr = op_q.addr ^ ADDR_W'(1);
        ram_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_d;
    end
    if (load) begin
      out_np_q  <= pos.np;
      out_cnt_q <= pos.count;
      out_ne_q  <= word_b[pos.np[OFF_W-1:0]];
      out_ab_q  <= pos.all_bad;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign next_page_out_o  = out_np_q;
  assign next_count_out_o = out_cnt_q;
  assign need_erase_o     = out_ne_q;
  assign all_bad_o        = out_ab_q;

`ifndef SYNTH
  a_accept_to_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_WB))
    else $error("accepted transaction did not reach write-back");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ram_we)
    else $error("bitmap written while idle");

  a_load_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_WB))
    else $error("result loaded outside write-back");

  a_clr2_only_wide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR2) |-> (op_q.clr2 && $past(state_q == ST_WB)))
    else $error("second clear cycle without wide block erase");
`endif

endmodule

/* tb/sv/flrt_slot_checker.sv */
`timescale 1ns / 100ps
// Slot checker for the flash ring log slot tracker: follows register writes and events,
// predicts the slot report of each event and compares it with the reported one.
// Depends on flrt_pkg.
module flrt_slot_checker
  import flrt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic [2:0]         mode_i,
  input  logic [PAGE_W-1:0]  page_i,
  input  logic               page_bad_i,
  input  logic               read_ok_i,
  input  logic [CNT_W-1:0]   seq_word_i,
  input  logic [CNT_W-1:0]   magic_word_i,
  input  logic               panic_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [PAGE_W-1:0]  next_page_out_o,
  input  logic [CNT_W-1:0]   next_count_out_o,
  input  logic               need_erase_o,
  input  logic               all_bad_o,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [CNT_W-1:0]  count;
    logic              need_erase;
    logic              all_bad;
  } slot_t;

  logic [MAX_PAGES-1:0] used_map;
  logic [31:0]          wr_page;
  logic [CNT_W-1:0]     wr_count;
  logic [CNT_W-1:0]     best_seq;
  logic [31:0]          best_pg;
  logic [31:0]          skips;
  logic [NPCFG_W-1:0]   cfg_pages;
  logic [L2CFG_W-1:0]   cfg_log2;
  slot_t                exp_slots[$];
  slot_t                want;
  slot_t                fresh;
  int                   fails;

  assign fail_count_o = fails;

  function automatic logic [31:0] page_count();
    logic [31:0] n;
    n = cfg_pages;
    if (n > MAX_PAGES) n = MAX_PAGES;
    if (n == 0) n = 1;
    return n;
  endfunction

  function automatic logic walk_ended();
    return (skips != 0) && (skips >= (page_count() >> cfg_log2));
  endfunction

  function automatic logic page_used(logic [31:0] p);
    return (p < MAX_PAGES) ? used_map[p[PAGE_W-1:0]] : 1'b0;
  endfunction

  task automatic mark(logic [31:0] p, logic used);
    if (p < MAX_PAGES) used_map[p[PAGE_W-1:0]] = used;
  endtask

  task automatic wrap();
    if (wr_page >= page_count()) wr_page = 0;
  endtask

  task automatic bump();
    wr_page++;
    wrap();
    wr_count++;
    if (wr_count == NONE_SEQ) wr_count = '0;
  endtask

  task automatic track_event(input logic [2:0] mode, input logic [PAGE_W-1:0] pg,
                             input logic bad, input logic ok, input logic [CNT_W-1:0] seq,
                             input logic [CNT_W-1:0] magic, input logic panic,
                             output slot_t slot);
    logic [31:0] ppb;
    logic [31:0] base;
    logic [31:0] offs;
    logic        take;
    ppb = 32'd1 << cfg_log2;
    case (mode)
      MODE_SCAN: begin
        if (pg < page_count() && !bad) begin
          mark(pg, 1'b1);
          if (ok) begin
            if (seq == NONE_SEQ && magic == NONE_SEQ) mark(pg, 1'b0);
            if (seq != NONE_SEQ && magic == REC_MAGIC) begin
              take = 1'b0;
              if (best_seq == NONE_SEQ) take = 1'b1;
              else if (seq < SEQ_LOW && best_seq > SEQ_HIGH) take = 1'b1;
              else if (seq > best_seq && seq < SEQ_HIGH) take = 1'b1;
              else if (seq > best_seq && seq > SEQ_HIGH && best_seq > SEQ_HALF) take = 1'b1;
              if (take) begin
                best_seq = seq;
                best_pg  = pg;
              end
            end
          end
        end
      end
      MODE_FINISH: begin
        if (best_seq == NONE_SEQ) begin
          wr_page  = page_count() - 1;
          wr_count = '0;
        end else begin
          wr_page  = best_pg;
          wr_count = best_seq;
        end
        best_seq = NONE_SEQ;
        best_pg  = 0;
        bump();
      end
      MODE_WRITE: begin
        mark(wr_page, 1'b1);
        if (!panic) bump();
      end
      MODE_ALIGN: begin
        skips = 0;
        offs  = wr_page & (ppb - 1);
        if (offs != 0) begin
          wr_page += ppb - offs;
          wrap();
        end
      end
      MODE_BAD: begin
        if (!walk_ended()) begin
          skips++;
          wr_page += ppb;
          wrap();
        end
      end
      MODE_ERASED: begin
        base = wr_page & ~(ppb - 1);
        for (int i = 0; i < ppb; i++) mark(base + i, 1'b0);
      end
      default: ;
    endcase
    slot = '{wr_page[PAGE_W-1:0], wr_count, page_used(wr_page), walk_ended()};
  endtask

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      fails++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_map  = '0;
      wr_page   = 0;
      wr_count  = '0;
      best_seq  = NONE_SEQ;
      best_pg   = 0;
      skips     = 0;
      cfg_pages = NUM_PAGES_RST;
      cfg_log2  = PPB_LOG2_RST;
      exp_slots.delete();
      pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr >> 2)
          REG_NUM_PAGES: cfg_pages = pwdata[NPCFG_W-1:0];
          REG_PPB_LOG2:  cfg_log2  = pwdata[L2CFG_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        if (exp_slots.size() == 0) begin
          fails++;
          $display("%0t: slot report with none expected, actual page %h count %h", $time,
                   next_page_out_o, next_count_out_o);
        end else begin
          want = exp_slots.pop_front();
          check_field("next_page", want.page, next_page_out_o);
          check_field("next_count", want.count, next_count_out_o);
          check_field("need_erase", want.need_erase, need_erase_o);
          check_field("all_bad", want.all_bad, all_bad_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        track_event(mode_i, page_i, page_bad_i, read_ok_i, seq_word_i, magic_word_i, panic_i,
                    fresh);
        exp_slots.push_back(fresh);
      end
      pending_o <= exp_slots.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Top of the slot tracker testbench: clock, reset, register writes, event stimulus and verdict.
// Depends on flrt_pkg, flash_ring_log_slot_tracker_core and flrt_slot_checker.
module tb_top;
  import flrt_pkg::*;

  localparam logic [2:0] MODE_SPARE6     = 3'd6;
  localparam logic [2:0] MODE_SPARE7     = 3'd7;
  localparam int         NUM_PHASES      = 10;
  localparam int         ITEMS_PER_PHASE = 75;
  localparam int         QUIET_LIMIT     = 4000;

  typedef struct packed {
    logic [2:0]        mode;
    logic [PAGE_W-1:0] page;
    logic              page_bad;
    logic              read_ok;
    logic [CNT_W-1:0]  seq;
    logic [CNT_W-1:0]  magic;
    logic              panic;
  } flash_ev_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         mode_i;
  logic [PAGE_W-1:0]  page_i;
  logic               page_bad_i;
  logic               read_ok_i;
  logic [CNT_W-1:0]   seq_word_i;
  logic [CNT_W-1:0]   magic_word_i;
  logic               panic_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [PAGE_W-1:0]  next_page_out_o;
  logic [CNT_W-1:0]   next_count_out_o;
  logic               need_erase_o;
  logic               all_bad_o;
  int                 fail_count;
  int                 pending;

  int burst_left;
  int stall_left;
  int stall_style;
  int quiet_cycles;

  logic [NPCFG_W-1:0] ph_pages [NUM_PHASES] =
    '{13'd2, 13'd0, 13'd8191, 13'd4096, 13'd5, 13'd1, 13'd40, 13'd16, 13'd300, 13'd4095};
  logic [L2CFG_W-1:0] ph_log2 [NUM_PHASES] =
    '{3'd0, 3'd7, 3'd7, 3'd6, 3'd3, 3'd0, 3'd2, 3'd4, 3'd1, 3'd5};

  flash_ring_log_slot_tracker_core uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .mode_i, .page_i, .page_bad_i, .read_ok_i, .seq_word_i,
    .magic_word_i, .panic_i, .out_valid_o, .out_stall_i, .next_page_out_o,
    .next_count_out_o, .need_erase_o, .all_bad_o
  );

  flrt_slot_checker checker_i (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid_i, .in_stall_o, .mode_i, .page_i, .page_bad_i, .read_ok_i, .seq_word_i,
    .magic_word_i, .panic_i, .out_valid_o, .out_stall_i, .next_page_out_o,
    .next_count_out_o, .need_erase_o, .all_bad_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(8, 64);
    end
    stall_left--;
    case (stall_style)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 99) < 30);
      2:       out_stall_i <= ($urandom_range(0, 99) < 75);
      default: out_stall_i <= stall_left[2];
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic flash_ev_t ev(logic [2:0] m, logic [PAGE_W-1:0] p, logic bad, logic ok,
                                   logic [CNT_W-1:0] s, logic [CNT_W-1:0] mg, logic pn);
    return '{m, p, bad, ok, s, mg, pn};
  endfunction

  function automatic flash_ev_t rand_ev(logic [2:0] m);
    return '{m, PAGE_W'($urandom_range(0, MAX_PAGES - 1)), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)), $urandom, $urandom, 1'($urandom_range(0, 1))};
  endfunction

  function automatic logic [CNT_W-1:0] pick_seq_base();
    case ($urandom_range(0, 5))
      0:       return NONE_SEQ - 32'd12;
      1:       return SEQ_LOW - 32'd8;
      2:       return SEQ_HIGH - 32'd8;
      3:       return SEQ_HALF - 32'd4;
      4:       return $urandom;
      default: return $urandom_range(0, 20);
    endcase
  endfunction

  task automatic send(flash_ev_t e);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    mode_i       <= e.mode;
    page_i       <= e.page;
    page_bad_i   <= e.page_bad;
    read_ok_i    <= e.read_ok;
    seq_word_i   <= e.seq;
    magic_word_i <= e.magic;
    panic_i      <= e.panic;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_idx_e idx, logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    flash_ev_t   e;
    int          eff;
    int          len;
    int          start;
    int          n;
    int          r;
    logic [31:0] base;

    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_valid_i   <= 1'b0;
    mode_i       <= MODE_SCAN;
    page_i       <= '0;
    page_bad_i   <= 1'b0;
    read_ok_i    <= 1'b0;
    seq_word_i   <= '0;
    magic_word_i <= '0;
    panic_i      <= 1'b0;
    burst_left   = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(ev(MODE_SPARE6, 12'hfff, 1'b1, 1'b1, '1, '1, 1'b1));
    send(ev(MODE_SCAN, 12'hfff, 1'b0, 1'b1, 32'd5, REC_MAGIC, 1'b0));
    send(ev(MODE_SCAN, 12'd0, 1'b1, 1'b1, 32'd7, REC_MAGIC, 1'b0));
    send(ev(MODE_SCAN, 12'd1, 1'b0, 1'b0, 32'd8, REC_MAGIC, 1'b0));
    send(ev(MODE_SCAN, 12'd2, 1'b0, 1'b1, NONE_SEQ, NONE_SEQ, 1'b0));
    send(ev(MODE_SCAN, 12'd3, 1'b0, 1'b1, NONE_SEQ, REC_MAGIC, 1'b0));
    send(ev(MODE_SCAN, 12'd4, 1'b0, 1'b1, 32'd9, ~REC_MAGIC, 1'b0));
    send(ev(MODE_SCAN, 12'd5, 1'b0, 1'b1, SEQ_HIGH + 32'd1, REC_MAGIC, 1'b0));
    send(ev(MODE_FINISH, '0, 1'b0, 1'b0, '0, '0, 1'b0));
    send(ev(MODE_WRITE, '0, 1'b0, 1'b0, '0, '0, 1'b0));
    send(ev(MODE_WRITE, '0, 1'b0, 1'b0, '0, '0, 1'b1));
    send(ev(MODE_SCAN, 12'd7, 1'b0, 1'b1, SEQ_HIGH - 32'd1, REC_MAGIC, 1'b0));
    send(ev(MODE_SCAN, 12'd8, 1'b0, 1'b1, SEQ_HIGH, REC_MAGIC, 1'b0));
    send(ev(MODE_SCAN, 12'd9, 1'b0, 1'b1, SEQ_HIGH + 32'd5, REC_MAGIC, 1'b0));
    send(ev(MODE_SCAN, 12'd10, 1'b0, 1'b1, SEQ_LOW - 32'd1, REC_MAGIC, 1'b0));
    send(ev(MODE_SCAN, 12'd11, 1'b0, 1'b1, SEQ_LOW, REC_MAGIC, 1'b0));
    send(ev(MODE_FINISH, '0, 1'b0, 1'b0, '0, '0, 1'b0));
    send(ev(MODE_ALIGN, '0, 1'b0, 1'b0, '0, '0, 1'b0));
    send(ev(MODE_BAD, '0, 1'b0, 1'b0, '0, '0, 1'b0));
    send(ev(MODE_BAD, '0, 1'b0, 1'b0, '0, '0, 1'b0));
    send(ev(MODE_ERASED, '0, 1'b0, 1'b0, '0, '0, 1'b0));
    send(ev(MODE_FINISH, '0, 1'b0, 1'b0, '0, '0, 1'b0));
    send(ev(MODE_SPARE7, '0, 1'b0, 1'b0, '0, '0, 1'b0));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      apb_write(REG_NUM_PAGES, PDATA_W'(ph_pages[ph]));
      apb_write(REG_PPB_LOG2, PDATA_W'(ph_log2[ph]));
      eff = (ph_pages[ph] > MAX_PAGES) ? MAX_PAGES : ph_pages[ph];
      if (eff == 0) eff = 1;
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 9);
        if (r < 4) begin
          len   = $urandom_range(1, (eff < 22) ? eff + 2 : 24);
          start = $urandom_range(0, eff - 1);
          base  = pick_seq_base();
          for (int k = 0; k < len; k++) begin
            e      = rand_ev(MODE_SCAN);
            e.page = PAGE_W'(start + k);
            r      = $urandom_range(0, 99);
            e.page_bad = (r < 6);
            e.read_ok  = !(r >= 6 && r < 12);
            if (r >= 12 && r < 20) begin
              e.seq   = NONE_SEQ;
              e.magic = NONE_SEQ;
            end else if (r >= 26) begin
              e.seq   = base + k;
              e.magic = REC_MAGIC;
            end
            if (r >= 96) base = pick_seq_base();
            send(e);
            n++;
          end
          send(rand_ev(MODE_FINISH));
          n++;
        end else if (r < 9) begin
          repeat ($urandom_range(3, 12)) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
              e       = rand_ev(MODE_WRITE);
              e.panic = ($urandom_range(0, 99) < 20);
            end else if (r < 55) e = rand_ev(MODE_ALIGN);
            else if (r < 75) e = rand_ev(MODE_BAD);
            else if (r < 90) e = rand_ev(MODE_ERASED);
            else if (r < 95) e = rand_ev(MODE_FINISH);
            else e = rand_ev(MODE_SCAN);
            send(e);
            n++;
          end
        end else begin
          send(rand_ev(($urandom_range(0, 1) == 0) ? MODE_SPARE6 : MODE_SPARE7));
          n++;
        end
      end
    end

    drain();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
